/* hw/rtl/servo_command_frame_parser_macros.svh */
// Assertion helpers used by the parser RTL, which checks itself.
`ifndef SERVO_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERVO_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SCFP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SCFP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/scfp_pkg.sv */
`default_nettype none

package scfp_pkg;

	localparam int BUFFER_BYTES_DEFAULT = 128;
	localparam int MAX_FIELDS = 4;
	localparam int MAX_RESULTS = 3;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_N     = 8'h6E;

	localparam logic [7:0] ADDR_GAIN     = 8'd28;
	localparam logic [7:0] ADDR_POSITION = 8'd30;
	localparam logic [7:0] ADDR_SPEED    = 8'd32;

	localparam logic [15:0] DEFAULT_GAIN_RESET = 16'd3;
	localparam logic [14:0] GAIN_LIMIT_RESET   = 15'd32;

	localparam logic CFG_DEFAULT_GAIN = 1'b0;
	localparam logic CFG_GAIN_LIMIT   = 1'b1;

	localparam logic KIND_WRITE    = 1'b0;
	localparam logic KIND_IDENTITY = 1'b1;

	localparam logic [2:0] FIELDS_OVER = 3'd5;

	typedef enum logic [1:0] {
		PM_NONE  = 2'd0,
		PM_G     = 2'd1,
		PM_GN    = 2'd2,
		PM_NO    = 2'd3
	} prefix_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  servo_id;
		logic [7:0]  reg_address;
		logic [15:0] reg_value;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/servo_command_frame_parser.sv */
// Servo command frame parser. Bytes enter on s_axis (tdata bits 7:0), are
// registered, and while no closing byte is held, one byte is parsed per clock
// and a new byte can be taken every cycle. A '>' that closes a valid frame
// loads up to three register writes (or one identity reply) into a three-entry
// result queue that drains on m_axis one transaction per cycle while
// m_axis_tready is high, tlast marking the final one of the frame. A closing
// byte that has results waits in the input register until the queue is empty
// or emptying. Configuration writes on the cfg channel are always accepted:
// index 0 is the default gain, index 1 the gain limit.
`default_nettype none

module servo_command_frame_parser #(
	parameter int BUFFER_BYTES = scfp_pkg::BUFFER_BYTES_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] servo_id, [15:8] reg_address, [31:16] reg_value
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);
	import scfp_pkg::*;

	localparam int BC_W = $clog2(BUFFER_BYTES);

	logic [15:0]     default_gain_q;
	logic [14:0]     gain_limit_q;

	logic            s1_valid_q;
	logic [7:0]      byte_s1;

	logic            collecting_q;
	logic [BC_W-1:0] byte_count_q;
	logic [2:0]      field_count_q;
	logic            in_field_q;
	logic            digits_done_q;
	logic            sign_seen_q;
	logic            field_negative_q;
	logic [15:0]     accumulator_q;
	logic [15:0]     field_values_q [MAX_FIELDS];
	prefix_t         prefix_match_q;
	logic            zero_seen_q;

	logic            nx_collecting;
	logic [BC_W-1:0] nx_byte_count;
	logic [2:0]      nx_field_count;
	logic            nx_in_field;
	logic            nx_digits_done;
	logic            nx_sign_seen;
	logic            nx_field_negative;
	logic [15:0]     nx_accumulator;
	logic [15:0]     nx_field_values [MAX_FIELDS];
	prefix_t         nx_prefix_match;
	logic            nx_zero_seen;

	logic [15:0]     fin_values [MAX_FIELDS];
	result_t         new_res [MAX_RESULTS];
	logic [1:0]      new_n;

	result_t         res_q [MAX_RESULTS];
	logic [1:0]      out_cnt_q;
	logic            out_free;
	logic            s1_go;
	logic            m_hs;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_gain_q <= DEFAULT_GAIN_RESET;
			gain_limit_q <= GAIN_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEFAULT_GAIN: default_gain_q <= cfg_data;
				CFG_GAIN_LIMIT:   gain_limit_q <= cfg_data[14:0];
				default:          ;
			endcase
		end
	end

	assign m_hs = m_axis_tvalid && m_axis_tready;
	assign out_free = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && m_axis_tready);
	assign s1_go = s1_valid_q && ((new_n == 2'd0) || out_free);
	assign s_axis_tready = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// The field being closed, as it would stand after the closing step, and the results that a closing '>' loads.
	always_comb begin
		logic [15:0] v;
		logic [15:0] g;
		v = field_negative_q ? (16'd0 - accumulator_q) : accumulator_q;
		for (int i = 0; i < MAX_FIELDS; i++) begin
			fin_values[i] = field_values_q[i];
			if (in_field_q && field_count_q == 3'(i + 1)) begin
				fin_values[i] = v;
			end
		end
		g = fin_values[3];
		if (!g[15] && (g[14:0] > gain_limit_q)) begin
			g = {1'b0, gain_limit_q};
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			new_res[i] = '0;
			new_res[i].kind = KIND_WRITE;
			new_res[i].servo_id = fin_values[0][7:0];
		end
		new_n = 2'd0;
		if (s1_valid_q && byte_s1 == CH_GT && collecting_q) begin
			unique case (field_count_q)
				3'd1: begin
					if (prefix_match_q == PM_GN) begin
						new_res[0] = '0;
						new_res[0].kind = KIND_IDENTITY;
						new_n = 2'd1;
					end
				end
				3'd2: begin
					new_res[0].reg_address = ADDR_POSITION;
					new_res[0].reg_value = fin_values[1];
					new_n = 2'd1;
				end
				3'd3: begin
					new_res[0].reg_address = ADDR_GAIN;
					new_res[0].reg_value = default_gain_q;
					new_res[1].reg_address = ADDR_SPEED;
					new_res[1].reg_value = fin_values[2];
					new_res[2].reg_address = ADDR_POSITION;
					new_res[2].reg_value = fin_values[1];
					new_n = 2'd3;
				end
				3'd4: begin
					new_res[0].reg_address = ADDR_GAIN;
					new_res[0].reg_value = g;
					if (fin_values[2] != 16'd0) begin
						new_res[1].reg_address = ADDR_SPEED;
						new_res[1].reg_value = fin_values[2];
						new_res[2].reg_address = ADDR_POSITION;
						new_res[2].reg_value = fin_values[1];
						new_n = 2'd3;
					end else begin
						new_res[1].reg_address = ADDR_POSITION;
						new_res[1].reg_value = fin_values[1];
						new_n = 2'd2;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       restart;
		logic       close;
		logic       chr;
		logic       zero;
		c = byte_s1;
		restart = 1'b0;
		close = 1'b0;
		chr = 1'b0;
		zero = 1'b0;
		nx_collecting = collecting_q;
		nx_byte_count = byte_count_q;
		nx_field_count = field_count_q;
		nx_in_field = in_field_q;
		nx_digits_done = digits_done_q;
		nx_sign_seen = sign_seen_q;
		nx_field_negative = field_negative_q;
		nx_accumulator = accumulator_q;
		nx_prefix_match = prefix_match_q;
		nx_zero_seen = zero_seen_q;
		for (int i = 0; i < MAX_FIELDS; i++) begin
			nx_field_values[i] = field_values_q[i];
		end

		if (c == CH_HASH) begin
			restart = 1'b0;
		end else if (c == CH_LT) begin
			nx_collecting = 1'b1;
			restart = 1'b1;
		end else if (c == CH_GT) begin
			nx_collecting = 1'b0;
			restart = 1'b1;
		end else if (collecting_q) begin
			if (byte_count_q == BC_W'(BUFFER_BYTES - 1)) begin
				restart = 1'b1;
			end
			if (!zero_seen_q || restart) begin
				if (c == CH_NUL) begin
					zero = 1'b1;
					close = 1'b1;
				end else if (c == CH_SPACE) begin
					close = 1'b1;
				end else begin
					chr = 1'b1;
				end
			end
		end

		if (restart) begin
			nx_byte_count = '0;
			nx_field_count = '0;
			nx_in_field = 1'b0;
			nx_digits_done = 1'b0;
			nx_sign_seen = 1'b0;
			nx_field_negative = 1'b0;
			nx_accumulator = '0;
			nx_prefix_match = PM_NONE;
			nx_zero_seen = 1'b0;
			for (int i = 0; i < MAX_FIELDS; i++) begin
				nx_field_values[i] = '0;
			end
		end
		if (zero) begin
			nx_zero_seen = 1'b1;
		end

		if (collecting_q && c != CH_HASH && c != CH_LT && c != CH_GT) begin
			nx_byte_count = nx_byte_count + BC_W'(1);
		end

		if (close && nx_in_field) begin
			for (int i = 0; i < MAX_FIELDS; i++) begin
				if (nx_field_count == 3'(i + 1)) begin
					nx_field_values[i] = nx_field_negative ?
						(16'd0 - nx_accumulator) : nx_accumulator;
				end
			end
		end
		if (close) begin
			nx_in_field = 1'b0;
		end

		if (chr) begin
			if (!nx_in_field) begin
				nx_in_field = 1'b1;
				nx_digits_done = 1'b0;
				nx_sign_seen = 1'b0;
				nx_field_negative = 1'b0;
				nx_accumulator = '0;
				if (nx_field_count != FIELDS_OVER) begin
					nx_field_count = nx_field_count + 3'd1;
				end
				if (nx_field_count == 3'd1) begin
					nx_prefix_match = (c == CH_G) ? PM_G : PM_NO;
				end
			end else if (nx_field_count == 3'd1 && nx_prefix_match == PM_G) begin
				nx_prefix_match = (c == CH_N) ? PM_GN : PM_NO;
			end else if (nx_field_count == 3'd1 && nx_prefix_match == PM_NONE) begin
				nx_prefix_match = PM_NO;
			end
			if (!nx_digits_done) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					nx_sign_seen = 1'b1;
					nx_accumulator = (nx_accumulator << 3) + (nx_accumulator << 1)
						+ {12'd0, c[3:0]};
				end else if (!nx_sign_seen && c >= CH_TAB && c <= CH_CR) begin
					nx_digits_done = 1'b0;
				end else if (!nx_sign_seen && (c == CH_PLUS || c == CH_MINUS)) begin
					nx_sign_seen = 1'b1;
					nx_field_negative = (c == CH_MINUS);
				end else begin
					nx_digits_done = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b1;
			byte_count_q <= '0;
			field_count_q <= '0;
			in_field_q <= 1'b0;
			digits_done_q <= 1'b0;
			sign_seen_q <= 1'b0;
			field_negative_q <= 1'b0;
			accumulator_q <= '0;
			prefix_match_q <= PM_NONE;
			zero_seen_q <= 1'b0;
			for (int i = 0; i < MAX_FIELDS; i++) begin
				field_values_q[i] <= '0;
			end
		end else if (s1_go) begin
			collecting_q <= nx_collecting;
			byte_count_q <= nx_byte_count;
			field_count_q <= nx_field_count;
			in_field_q <= nx_in_field;
			digits_done_q <= nx_digits_done;
			sign_seen_q <= nx_sign_seen;
			field_negative_q <= nx_field_negative;
			accumulator_q <= nx_accumulator;
			prefix_match_q <= nx_prefix_match;
			zero_seen_q <= nx_zero_seen;
			for (int i = 0; i < MAX_FIELDS; i++) begin
				field_values_q[i] <= nx_field_values[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (s1_go && new_n != 2'd0) begin
			out_cnt_q <= new_n;
		end else if (m_hs) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && new_n != 2'd0) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= new_res[i];
			end
		end else if (m_hs) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	assign m_axis_tvalid = (out_cnt_q != 2'd0);
	assign m_axis_tlast = (out_cnt_q == 2'd1);
	assign m_axis_tuser = res_q[0].kind;
	assign m_axis_tdata = {res_q[0].reg_value, res_q[0].reg_address, res_q[0].servo_id};

	`include "servo_command_frame_parser_macros.svh"

	`SCFP_ASSERT_IMP(a_idle_no_count, !collecting_q, byte_count_q == '0,
		"Byte count advanced outside a frame.")
	`SCFP_ASSERT_IMP(a_field_counted, in_field_q, field_count_q != 3'd0,
		"Open field without a field count.")
	`SCFP_ASSERT_NXT(a_open_restarts, s1_go && byte_s1 == CH_LT,
		collecting_q && field_count_q == 3'd0 && !zero_seen_q,
		"Frame start did not restart collection.")
	`SCFP_ASSERT_IMP(a_load_when_free, s1_go && new_n != 2'd0, out_free,
		"Results loaded over undelivered results.")

endmodule

`default_nettype wire
